>>> rtl/plst_pkg.sv
`default_nettype none

package plst_pkg;

  // Default list depth
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned DROP_W  = 7;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned LEN_W   = 7;

  // Packed stream widths, rounded up to whole bytes
  localparam int unsigned IN_BITS  = REQ_W + COLOR_W + POS_W + DROP_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = STAT_W + COLOR_W + LEN_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT   = 3'd0,
    REQ_APPEND       = 3'd1,
    REQ_INSERT_AFTER = 3'd2,
    REQ_POP_FRONT    = 3'd3,
    REQ_POP_AT       = 3'd4,
    REQ_LENGTH       = 3'd5,
    REQ_DROP_LAST    = 3'd6
  } plst_req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_COUNT = 3'd4
  } plst_status_e;

  // What every cell does at a clock edge
  typedef enum logic [1:0] {
    SHIFT_HOLD   = 2'd0,
    SHIFT_INSERT = 2'd1,
    SHIFT_REMOVE = 2'd2
  } plst_shift_e;

  typedef struct packed {
    plst_shift_e        op;
    logic [COLOR_W-1:0] color;
  } plst_cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/plst_cell.sv
`default_nettype none

module plst_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire                           clk_i,
  input  wire plst_pkg::plst_cell_ctl_t ctl_i,
  input  wire [IDX_W-1:0]               sel_idx_i,
  input  wire [plst_pkg::COLOR_W-1:0]   left_i,
  input  wire [plst_pkg::COLOR_W-1:0]   right_i,
  output logic [plst_pkg::COLOR_W-1:0]  val_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [plst_pkg::COLOR_W-1:0] val_d, val_q;

  // Pick the new entry: take from a neighbor, load the new colour, or hold
  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      plst_pkg::SHIFT_INSERT: begin
        if (MyIdx > sel_idx_i) val_d = left_i;
        else if (MyIdx == sel_idx_i) val_d = ctl_i.color;
      end
      plst_pkg::SHIFT_REMOVE: begin
        if (MyIdx >= sel_idx_i) val_d = right_i;
      end
      default: val_d = val_q;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

>>> rtl/positional_list_store.sv
`default_nettype none

// Channel   Dir  Fields (tdata, low bit first)
// s_axis    in   req_type[2:0] color_in[6:3] position[12:7] drop_count[19:13]
// m_axis    out  status[2:0] color_out[6:3] length_out[13:7]
//
// Barring the m_axis stall below, one request is taken per cycle; its result
// is registered and shows in the next cycle. Every cell of the row shifts,
// loads or holds as the request is taken, so the cells and the entry count
// are all the state carried between requests. Reset clears the count and the
// output valid; cell contents stay undefined. While a result waits on m_axis,
// a new request is taken only in the cycle the waiting result is taken.

module positional_list_store #(
  parameter int unsigned CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // req_type, color_in, position, drop_count, zero pad
  input  wire [plst_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire                        m_axis_tready_i,
  // status, color_out, length_out, zero pad
  output logic [plst_pkg::OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = (CW > plst_pkg::DROP_W) ? CW : plst_pkg::DROP_W;
  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

  // Unpack the request
  plst_pkg::plst_req_e             req;
  logic [plst_pkg::COLOR_W-1:0]    color_in;
  logic [plst_pkg::POS_W-1:0]      position;
  logic [plst_pkg::DROP_W-1:0]     drop_count;

  assign req        = plst_pkg::plst_req_e'(s_axis_tdata_i[2:0]);
  assign color_in   = s_axis_tdata_i[6:3];
  assign position   = s_axis_tdata_i[12:7];
  assign drop_count = s_axis_tdata_i[19:13];

  logic in_acc;
  logic out_valid_q;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  logic [CW-1:0] count_d, count_q;
  logic [CMPW-1:0] count_x, pos_x, drop_x;
  logic full, empty, pos_bad;

  assign count_x = CMPW'(count_q);
  assign pos_x   = CMPW'(position);
  assign drop_x  = CMPW'(drop_count);
  assign full    = (count_q >= CapVal);
  assign empty   = (count_q == '0);
  assign pos_bad = (pos_x >= count_x);

  // Cell row wiring
  logic [plst_pkg::COLOR_W-1:0] cell_val [CAPACITY];
  plst_pkg::plst_cell_ctl_t     ctl;
  logic [IW-1:0]                sel_idx;
  plst_pkg::plst_status_e       status;
  logic [plst_pkg::COLOR_W-1:0] removed;
  logic                         do_op;

  // Decode the request into status, new count and the row command
  always_comb begin
    status    = plst_pkg::ST_OK;
    removed   = '0;
    count_d   = count_q;
    do_op     = 1'b0;
    ctl.op    = plst_pkg::SHIFT_HOLD;
    ctl.color = color_in;
    sel_idx   = '0;
    case (req)
      plst_pkg::REQ_PUSH_FRONT: begin
        if (full) status = plst_pkg::ST_FULL;
        else begin
          do_op   = 1'b1;
          ctl.op  = plst_pkg::SHIFT_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      plst_pkg::REQ_APPEND: begin
        if (full) status = plst_pkg::ST_FULL;
        else begin
          do_op   = 1'b1;
          ctl.op  = plst_pkg::SHIFT_INSERT;
          sel_idx = IW'(count_q);
          count_d = count_q + 1'b1;
        end
      end
      plst_pkg::REQ_INSERT_AFTER: begin
        if (full) status = plst_pkg::ST_FULL;
        else if (pos_bad) status = plst_pkg::ST_RANGE;
        else begin
          do_op   = 1'b1;
          ctl.op  = plst_pkg::SHIFT_INSERT;
          sel_idx = IW'(pos_x + 1'b1);
          count_d = count_q + 1'b1;
        end
      end
      plst_pkg::REQ_POP_FRONT: begin
        if (empty) status = plst_pkg::ST_EMPTY;
        else begin
          do_op   = 1'b1;
          ctl.op  = plst_pkg::SHIFT_REMOVE;
          removed = cell_val[0];
          count_d = count_q - 1'b1;
        end
      end
      plst_pkg::REQ_POP_AT: begin
        if (empty) status = plst_pkg::ST_EMPTY;
        else if (pos_bad) status = plst_pkg::ST_RANGE;
        else begin
          do_op   = 1'b1;
          ctl.op  = plst_pkg::SHIFT_REMOVE;
          sel_idx = IW'(pos_x);
          removed = cell_val[IW'(pos_x)];
          count_d = count_q - 1'b1;
        end
      end
      plst_pkg::REQ_DROP_LAST: begin
        if (drop_x > count_x) status = plst_pkg::ST_COUNT;
        else count_d = CW'(count_x - drop_x);
      end
      default: status = plst_pkg::ST_OK;
    endcase
    // Only an accepted request may move the row
    if (!in_acc) begin
      ctl.op  = plst_pkg::SHIFT_HOLD;
      do_op   = 1'b0;
    end
  end

  // Row of cells; each takes from its left or right neighbor
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [plst_pkg::COLOR_W-1:0] left_v, right_v;
    if (gi == 0) begin : g_first
      assign left_v = color_in;
    end else begin : g_mid_l
      assign left_v = cell_val[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[gi+1];
    end
    plst_cell #(
      .IDX_W    (IW),
      .CELL_IDX (gi)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .sel_idx_i (sel_idx),
      .left_i    (left_v),
      .right_i   (right_v),
      .val_o     (cell_val[gi])
    );
  end

  // Hold the entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_acc) begin
      count_q <= count_d;
    end
  end

  // Result register
  logic [plst_pkg::STAT_W-1:0]  res_status_q;
  logic [plst_pkg::COLOR_W-1:0] res_color_q;
  logic [plst_pkg::LEN_W-1:0]   res_len_q;
  logic [CMPW-1:0]              len_x;
  assign len_x = CMPW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_status_q <= status;
      res_color_q  <= removed;
      res_len_q    <= len_x[plst_pkg::LEN_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(plst_pkg::OUT_W - plst_pkg::OUT_BITS){1'b0}},
                            res_len_q, res_color_q, res_status_q};

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapVal)
    else $error("entry count above capacity");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req == plst_pkg::REQ_APPEND && !full) |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the list");

  a_fail_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_status_q != plst_pkg::ST_OK) |-> res_color_q == '0)
    else $error("failed request returned a colour");

  a_fail_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && status != plst_pkg::ST_OK) |-> (!do_op && count_d == count_q))
    else $error("refused request changed the list");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid_o)
    else $error("request produced no result");

endmodule

`default_nettype wire

>>> test/positional_list_store_tb.sv
`timescale 1ns / 1ps

module positional_list_store_tb;

  localparam int unsigned REQ_W   = plst_pkg::REQ_W;
  localparam int unsigned COLOR_W = plst_pkg::COLOR_W;
  localparam int unsigned POS_W   = plst_pkg::POS_W;
  localparam int unsigned DROP_W  = plst_pkg::DROP_W;
  localparam int unsigned STAT_W  = plst_pkg::STAT_W;
  localparam int unsigned LEN_W   = plst_pkg::LEN_W;
  localparam int unsigned IN_W    = plst_pkg::IN_W;
  localparam int unsigned IN_BITS = plst_pkg::IN_BITS;
  localparam int unsigned OUT_W   = plst_pkg::OUT_W;

  localparam int unsigned CAP         = plst_pkg::CAPACITY_DEF;
  localparam int unsigned RAND_ITEMS  = 1064;
  localparam int unsigned NUM_PHASES  = 4;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned NUM_ROWS    = 23;

  // Request code the block does not decode
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COLOR_W-1:0] color;
    logic [LEN_W-1:0]   len;
  } list_res_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   pos;
    logic [DROP_W-1:0]  drop;
    logic [7:0]         rep;
    logic               typed;
    list_res_t          res;
  } step_row_t;

  // Directed requests; typed results where obvious, predictor elsewhere
  localparam step_row_t STEP_TAB [0:NUM_ROWS-1] = '{
    '{plst_pkg::REQ_POP_FRONT,    4'd0,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_EMPTY, 4'd0,  7'd0}},
    '{plst_pkg::REQ_POP_AT,       4'd0,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_EMPTY, 4'd0,  7'd0}},
    '{plst_pkg::REQ_INSERT_AFTER, 4'd5,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_RANGE, 4'd0,  7'd0}},
    '{plst_pkg::REQ_LENGTH,       4'd0,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd0,  7'd0}},
    '{plst_pkg::REQ_DROP_LAST,    4'd0,  6'd0,  7'd1,   8'd1,  1'b1,
      '{plst_pkg::ST_COUNT, 4'd0,  7'd0}},
    '{plst_pkg::REQ_DROP_LAST,    4'd0,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd0,  7'd0}},
    '{REQ_UNUSED,                 4'd15, 6'd63, 7'd127, 8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd0,  7'd0}},
    '{plst_pkg::REQ_PUSH_FRONT,   4'd15, 6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd0,  7'd1}},
    '{plst_pkg::REQ_APPEND,       4'd0,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd0,  7'd2}},
    '{plst_pkg::REQ_INSERT_AFTER, 4'd9,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd0,  7'd3}},
    '{plst_pkg::REQ_INSERT_AFTER, 4'd1,  6'd3,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_RANGE, 4'd0,  7'd3}},
    '{plst_pkg::REQ_POP_AT,       4'd0,  6'd3,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_RANGE, 4'd0,  7'd3}},
    '{plst_pkg::REQ_POP_AT,       4'd0,  6'd1,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd9,  7'd2}},
    '{plst_pkg::REQ_POP_FRONT,    4'd0,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd15, 7'd1}},
    '{plst_pkg::REQ_APPEND,       4'd8,  6'd0,  7'd0,   8'd63, 1'b0,
      '{plst_pkg::ST_OK,    4'd0,  7'd0}},
    '{plst_pkg::REQ_PUSH_FRONT,   4'd1,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_FULL,  4'd0,  7'd64}},
    '{plst_pkg::REQ_APPEND,       4'd2,  6'd0,  7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_FULL,  4'd0,  7'd64}},
    '{plst_pkg::REQ_INSERT_AFTER, 4'd3,  6'd63, 7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_FULL,  4'd0,  7'd64}},
    '{plst_pkg::REQ_POP_AT,       4'd0,  6'd63, 7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd8,  7'd63}},
    '{plst_pkg::REQ_INSERT_AFTER, 4'd12, 6'd62, 7'd0,   8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd0,  7'd64}},
    '{plst_pkg::REQ_DROP_LAST,    4'd0,  6'd0,  7'd65,  8'd1,  1'b1,
      '{plst_pkg::ST_COUNT, 4'd0,  7'd64}},
    '{plst_pkg::REQ_DROP_LAST,    4'd0,  6'd0,  7'd127, 8'd1,  1'b1,
      '{plst_pkg::ST_COUNT, 4'd0,  7'd64}},
    '{plst_pkg::REQ_DROP_LAST,    4'd0,  6'd0,  7'd64,  8'd1,  1'b1,
      '{plst_pkg::ST_OK,    4'd0,  7'd0}}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_valid = 1'b0;
  logic [IN_W-1:0]   s_data = '0;
  logic              m_ready = 1'b0;
  logic              s_ready;
  logic              m_valid;
  logic [OUT_W-1:0]  m_data;

  // Shadow copy of the list
  logic [COLOR_W-1:0] shadow_cells [0:CAP-1];
  int                 shadow_count = 0;

  list_res_t result_q [$];
  logic      cur_typed = 1'b0;
  list_res_t cur_res = '0;
  logic      grow = 1'b1;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int cycle_count = 0;
  int errors = 0;
  int reqs_taken = 0;
  int results_seen = 0;
  int peak_len = 0;
  int status_hits [0:7];

  positional_list_store u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Give up if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_error(input string what);
    errors++;
    if (errors <= MAX_SHOWN) $display("ERROR: %s", what);
  endtask

  // Open a gap at idx and store the colour there
  task automatic open_slot(input int idx, input logic [COLOR_W-1:0] color);
    for (int i = shadow_count; i > idx; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[idx] = color;
    shadow_count++;
  endtask

  // Close the gap at idx and hand back the colour held there
  task automatic remove_slot(input int idx, output logic [COLOR_W-1:0] color);
    color = shadow_cells[idx];
    for (int i = idx; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
    shadow_count--;
  endtask

  // Apply one request to the shadow list and work out its result
  task automatic apply_list_req(input logic [REQ_W-1:0] req, input logic [COLOR_W-1:0] color,
                                input logic [POS_W-1:0] pos, input logic [DROP_W-1:0] drop,
                                output list_res_t res);
    logic full;
    res = '0;
    res.status = plst_pkg::ST_OK;
    full = (shadow_count >= CAP);
    case (req)
      plst_pkg::REQ_PUSH_FRONT: begin
        if (full) res.status = plst_pkg::ST_FULL;
        else open_slot(0, color);
      end
      plst_pkg::REQ_APPEND: begin
        if (full) res.status = plst_pkg::ST_FULL;
        else open_slot(shadow_count, color);
      end
      plst_pkg::REQ_INSERT_AFTER: begin
        if (full) res.status = plst_pkg::ST_FULL;
        else if (int'(pos) >= shadow_count) res.status = plst_pkg::ST_RANGE;
        else open_slot(int'(pos) + 1, color);
      end
      plst_pkg::REQ_POP_FRONT: begin
        if (shadow_count == 0) res.status = plst_pkg::ST_EMPTY;
        else remove_slot(0, res.color);
      end
      plst_pkg::REQ_POP_AT: begin
        if (shadow_count == 0) res.status = plst_pkg::ST_EMPTY;
        else if (int'(pos) >= shadow_count) res.status = plst_pkg::ST_RANGE;
        else remove_slot(int'(pos), res.color);
      end
      plst_pkg::REQ_DROP_LAST: begin
        if (int'(drop) > shadow_count) res.status = plst_pkg::ST_COUNT;
        else shadow_count -= int'(drop);
      end
      default: begin
      end
    endcase
    res.len = shadow_count[LEN_W-1:0];
    if (shadow_count > peak_len) peak_len = shadow_count;
  endtask

  // Check results against the oldest expectation, then predict new requests
  always @(posedge clk_i) begin
    list_res_t got;
    list_res_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got.status = m_data[STAT_W-1:0];
        got.color  = m_data[STAT_W +: COLOR_W];
        got.len    = m_data[STAT_W+COLOR_W +: LEN_W];
        status_hits[got.status]++;
        if (result_q.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d color %0d length %0d",
                               got.status, got.color, got.len));
        end else begin
          want = result_q.pop_front();
          if (got != want)
            flag_error($sformatf({"result %0d: expected status %0d color %0d length %0d,",
                                  " got status %0d color %0d length %0d"}, results_seen,
                                 want.status, want.color, want.len,
                                 got.status, got.color, got.len));
        end
        results_seen++;
      end
      if (s_valid && s_ready) begin
        apply_list_req(s_data[REQ_W-1:0], s_data[REQ_W +: COLOR_W],
                       s_data[REQ_W+COLOR_W +: POS_W], s_data[REQ_W+COLOR_W+POS_W +: DROP_W],
                       want);
        if (cur_typed) want = cur_res;
        result_q.push_back(want);
        reqs_taken++;
      end
    end
  end

  // Result side: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one request from a falling edge and hold it until taken
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [COLOR_W-1:0] color,
                          input logic [POS_W-1:0] pos, input logic [DROP_W-1:0] drop,
                          input logic typed, input list_res_t res);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_data    <= {{(IN_W-IN_BITS){1'b0}}, drop, pos, color, req};
    s_valid   <= 1'b1;
    cur_typed = typed;
    cur_res   = res;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  // Mostly well-formed requests that wander the list between empty and full
  task automatic pick_req(output logic [REQ_W-1:0] req, output logic [COLOR_W-1:0] color,
                          output logic [POS_W-1:0] pos, output logic [DROP_W-1:0] drop);
    int roll;
    color = COLOR_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 10) begin
      req  = REQ_W'($urandom_range(0, 7));
      pos  = POS_W'($urandom_range(0, 63));
      drop = DROP_W'($urandom_range(0, 127));
      return;
    end
    if (shadow_count == 0) grow = 1'b1;
    else if (shadow_count >= CAP && $urandom_range(0, 3) == 0) grow = 1'b0;
    else if ($urandom_range(0, 79) == 0) grow = ~grow;
    roll = $urandom_range(0, 99);
    if (roll < (grow ? 60 : 25))
      req = REQ_W'($urandom_range(plst_pkg::REQ_PUSH_FRONT, plst_pkg::REQ_INSERT_AFTER));
    else if (roll < (grow ? 85 : 80))
      req = REQ_W'($urandom_range(plst_pkg::REQ_POP_FRONT, plst_pkg::REQ_POP_AT));
    else if (roll < (grow ? 92 : 88)) req = plst_pkg::REQ_LENGTH;
    else req = plst_pkg::REQ_DROP_LAST;
    if (shadow_count == 0) pos = '0;
    else if ($urandom_range(0, 99) < 15) pos = POS_W'(shadow_count);
    else pos = POS_W'($urandom_range(0, shadow_count - 1));
    if ($urandom_range(0, 9) == 0) drop = DROP_W'(shadow_count + $urandom_range(0, 1));
    else drop = DROP_W'($urandom_range(0, (shadow_count < 4) ? shadow_count : 4));
  endtask

  initial begin
    logic [REQ_W-1:0]   req;
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   pos;
    logic [DROP_W-1:0]  drop;
    for (int i = 0; i < 8; i++) status_hits[i] = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int n = 0; n < int'(STEP_TAB[r].rep); n++)
        send_req(STEP_TAB[r].req, STEP_TAB[r].color, STEP_TAB[r].pos, STEP_TAB[r].drop,
                 STEP_TAB[r].typed, STEP_TAB[r].res);
    end

    // Random requests under each idling mix
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      if (ph == 0 || ph == NUM_PHASES - 1) hold_token++;
      for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
        pick_req(req, color, pos, drop);
        send_req(req, color, pos, drop, 1'b0, '0);
      end
    end
    s_valid <= 1'b0;

    // Drain outstanding results
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (result_q.size() != 0) flag_error("results still outstanding at end of run");

    $display("Covered %0d requests and %0d results, peak list length %0d, %0d mismatches",
             reqs_taken, results_seen, peak_len, errors);
    $display("Status mix: ok %0d, empty %0d, range %0d, full %0d, count %0d",
             status_hits[plst_pkg::ST_OK], status_hits[plst_pkg::ST_EMPTY],
             status_hits[plst_pkg::ST_RANGE], status_hits[plst_pkg::ST_FULL],
             status_hits[plst_pkg::ST_COUNT]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/plst_pkg.sv
rtl/plst_cell.sv
rtl/positional_list_store.sv
test/positional_list_store_tb.sv
